/* hw/rtl/stmg_pkg.sv */
// Shared types, constants and codes for the spin trial move generator.
package stmg_pkg;

  localparam int unsigned SpinFracBits   = 14;
  localparam int unsigned RsqrtStepsDflt = 3;
  localparam int unsigned QueueDepthDflt = 4;

  localparam int unsigned VecW = 48;

  localparam logic [2:0] MODE_ADAPT    = 3'd0;
  localparam logic [2:0] MODE_FLIP     = 3'd1;
  localparam logic [2:0] MODE_UNIFORM  = 3'd2;
  localparam logic [2:0] MODE_CONE     = 3'd3;
  localparam logic [2:0] MODE_COMBINED = 3'd4;

  localparam logic [1:0] KIND_FLIP    = 2'd0;
  localparam logic [1:0] KIND_UNIFORM = 2'd1;
  localparam logic [1:0] KIND_CONE    = 2'd2;

  localparam logic [1:0] REG_MOVE_MODE      = 2'd0;
  localparam logic [1:0] REG_CONE_WIDTH     = 2'd1;
  localparam logic [1:0] REG_ADAPTIVE_WIDTH = 2'd2;

  localparam logic [31:0] R0_LOW  = 32'd912680550;
  localparam logic [31:0] R0_HIGH = 32'd644245094;
  localparam logic [31:0] THREE_Q30 = 32'hC000_0000;

  // One classified item between front and back.
  typedef struct packed {
    logic [1:0]                   kind;
    logic [2:0][VecW-1:0]         v;
  } q_entry_t;

  // Everything that travels down the normalization pipeline.
  typedef struct packed {
    logic [1:0]           kind;
    logic                 zero;
    logic [2:0]           neg;
    logic [2:0][VecW-1:0] a;
    logic [VecW-1:0]      m;
    logic [5:0]           pos;
    logic [2:0][59:0]     sq;
    logic                 scaled;
    logic [31:0]          xq;
    logic [31:0]          r;
    logic [33:0]          r2;
    logic [31:0]          t;
    logic [2:0][63:0]     p;
    logic [2:0][15:0]     flip_res;
  } pl_t;

endpackage

/* hw/rtl/stmg_front.sv */
// Front end: picks the move kind and forms the vector to be normalized.
module stmg_front (
  input  logic [2:0]           move_mode_i,
  input  logic [15:0]          cone_width_i,
  input  logic [15:0]          adaptive_width_i,
  input  logic [2:0][15:0]     old_i,
  input  logic [2:0][15:0]     gauss_i,
  input  logic [15:0]          pick_sample_i,
  output stmg_pkg::q_entry_t   entry_o
);

  logic [1:0]  kind;
  logic [15:0] width;
  logic [17:0] pick3;

  assign pick3 = {2'b00, pick_sample_i} + {1'b0, pick_sample_i, 1'b0};

  always_comb begin
    kind  = stmg_pkg::KIND_CONE;
    width = adaptive_width_i;
    unique case (move_mode_i)
      stmg_pkg::MODE_FLIP:    kind = stmg_pkg::KIND_FLIP;
      stmg_pkg::MODE_UNIFORM: kind = stmg_pkg::KIND_UNIFORM;
      stmg_pkg::MODE_CONE:    width = cone_width_i;
      stmg_pkg::MODE_COMBINED: begin
        kind  = pick3[17:16];
        width = cone_width_i;
      end
      default: begin
        kind  = stmg_pkg::KIND_CONE;
        width = adaptive_width_i;
      end
    endcase
  end

  logic signed [16:0] negold [3];
  logic signed [16:0] flipv  [3];
  logic signed [32:0] gw     [3];

  always_comb begin
    entry_o.kind = kind;
    for (int i = 0; i < 3; i++) begin
      negold[i] = -{old_i[i][15], old_i[i]};
      if (negold[i] > 17'sd16384) begin
        flipv[i] = 17'sd16384;
      end else if (negold[i] < -17'sd16384) begin
        flipv[i] = -17'sd16384;
      end else begin
        flipv[i] = negold[i];
      end
      gw[i] = $signed(gauss_i[i]) * $signed({1'b0, width});
      unique case (kind)
        stmg_pkg::KIND_FLIP:
          entry_o.v[i] = {{(stmg_pkg::VecW-17){flipv[i][16]}}, flipv[i]};
        stmg_pkg::KIND_UNIFORM:
          entry_o.v[i] = {{(stmg_pkg::VecW-16){gauss_i[i][15]}}, gauss_i[i]};
        default:
          entry_o.v[i] = ({{(stmg_pkg::VecW-16){old_i[i][15]}}, old_i[i]} << 24)
                       + ({{(stmg_pkg::VecW-33){gw[i][32]}}, gw[i]}
                          << stmg_pkg::SpinFracBits);
      endcase
    end
  end

endmodule

/* hw/rtl/stmg_queue.sv */
// Short queue of classified items between front and back.
module stmg_queue #(
  parameter int unsigned Depth = stmg_pkg::QueueDepthDflt
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  stmg_pkg::q_entry_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output stmg_pkg::q_entry_t head_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  stmg_pkg::q_entry_t mem_q [Depth];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

/* hw/rtl/stmg_back.sv */
// Back end: normalization pipeline with reciprocal square root and output register.
module stmg_back #(
  parameter int unsigned RsqrtSteps = stmg_pkg::RsqrtStepsDflt
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_vld_i,
  input  stmg_pkg::q_entry_t head_i,
  output logic               pop_o,
  output logic               out_vld_o,
  input  logic               out_rdy_i,
  output logic [2:0][15:0]   out_res_o,
  output logic [1:0]         out_kind_o,
  output logic               out_zero_o
);

  localparam int unsigned F  = stmg_pkg::SpinFracBits;
  localparam int unsigned NP = 6 + 3 * RsqrtSteps;

  stmg_pkg::pl_t stg_q [NP];
  stmg_pkg::pl_t stg_d [NP];
  logic [NP-1:0] vld_q;
  logic          en;

  logic               out_vld_q;
  logic [2:0][15:0]   res_q, res_d;
  logic [1:0]         kind_q;
  logic               zero_q;

  // The whole pipeline moves as one whenever the output register can take data.
  assign en    = !out_vld_q || out_rdy_i;
  assign pop_o = en && head_vld_i;

  // Stage 0: magnitudes, signs and the largest magnitude.
  always_comb begin
    stg_d[0] = '0;
    stg_d[0].kind = head_i.kind;
    for (int i = 0; i < 3; i++) begin
      stg_d[0].neg[i] = head_i.v[i][stmg_pkg::VecW-1];
      stg_d[0].a[i]   = head_i.v[i][stmg_pkg::VecW-1] ? -head_i.v[i] : head_i.v[i];
      stg_d[0].flip_res[i] = head_i.v[i][15:0];
    end
    stg_d[0].m = stg_d[0].a[0];
    if (stg_d[0].a[1] > stg_d[0].m) stg_d[0].m = stg_d[0].a[1];
    if (stg_d[0].a[2] > stg_d[0].m) stg_d[0].m = stg_d[0].a[2];
    stg_d[0].zero = (stg_d[0].m == '0);
  end

  // Stage 1: position of the leading one of the largest magnitude.
  always_comb begin
    stg_d[1] = stg_q[0];
    stg_d[1].pos = '0;
    for (int b = 0; b < stmg_pkg::VecW; b++) begin
      if (stg_q[0].m[b]) stg_d[1].pos = 6'(b);
    end
  end

  // Stage 2: block shift so the largest magnitude lands in [2^29, 2^30).
  always_comb begin
    stg_d[2] = stg_q[1];
    for (int i = 0; i < 3; i++) begin
      if (stg_q[1].pos >= 6'd29) begin
        stg_d[2].a[i] = stg_q[1].a[i] >> (stg_q[1].pos - 6'd29);
      end else begin
        stg_d[2].a[i] = stg_q[1].a[i] << (6'd29 - stg_q[1].pos);
      end
    end
  end

  // Stage 3: squares.
  always_comb begin
    stg_d[3] = stg_q[2];
    for (int i = 0; i < 3; i++) begin
      stg_d[3].sq[i] = stg_q[2].a[i][29:0] * stg_q[2].a[i][29:0];
    end
  end

  // Stage 4: sum of squares, range scaling and the starting estimate.
  logic [61:0] ssum, sadj;
  always_comb begin
    stg_d[4] = stg_q[3];
    ssum = {2'b00, stg_q[3].sq[0]} + {2'b00, stg_q[3].sq[1]} + {2'b00, stg_q[3].sq[2]};
    stg_d[4].scaled = (ssum[61:60] == 2'b00);
    sadj = stg_d[4].scaled ? (ssum << 2) : ssum;
    stg_d[4].xq = sadj[61:30];
    stg_d[4].r  = stg_d[4].xq[31] ? stmg_pkg::R0_HIGH : stmg_pkg::R0_LOW;
  end

  // Newton steps, three stages each: r*r, x*r*r with saturation, update of r.
  for (genvar k = 0; k < RsqrtSteps; k++) begin : g_step
    localparam int unsigned SA = 5 + 3 * k;
    logic [63:0] rr;
    logic [65:0] xr;
    logic [63:0] ru;
    logic [31:0] diff;

    always_comb begin
      stg_d[SA] = stg_q[SA-1];
      rr = stg_q[SA-1].r * stg_q[SA-1].r;
      stg_d[SA].r2 = rr[63:30];
    end

    always_comb begin
      stg_d[SA+1] = stg_q[SA];
      xr = stg_q[SA].xq * stg_q[SA].r2;
      if (xr[65:30] > {4'b0000, stmg_pkg::THREE_Q30}) begin
        stg_d[SA+1].t = stmg_pkg::THREE_Q30;
      end else begin
        stg_d[SA+1].t = xr[61:30];
      end
    end

    always_comb begin
      stg_d[SA+2] = stg_q[SA+1];
      diff = stmg_pkg::THREE_Q30 - stg_q[SA+1].t;
      ru = stg_q[SA+1].r * diff;
      stg_d[SA+2].r = ru[62:31];
    end
  end

  // Last pipeline stage: component times reciprocal length.
  always_comb begin
    stg_d[NP-1] = stg_q[NP-2];
    for (int i = 0; i < 3; i++) begin
      stg_d[NP-1].p[i] = {34'd0, stg_q[NP-2].a[i][29:0]} * {32'd0, stg_q[NP-2].r};
    end
  end

  // Output register input: round, saturate, restore sign; flip kept, zero cleared.
  logic [63:0] pr [3];
  logic [63:0] qv [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr[i] = stg_q[NP-1].scaled ? (stg_q[NP-1].p[i] << 1) : stg_q[NP-1].p[i];
      qv[i] = (pr[i] + (64'd1 << (59 - F))) >> (60 - F);
      if (qv[i] > (64'd1 << F)) qv[i] = 64'd1 << F;
      if (stg_q[NP-1].kind == stmg_pkg::KIND_FLIP) begin
        res_d[i] = stg_q[NP-1].flip_res[i];
      end else if (stg_q[NP-1].zero) begin
        res_d[i] = '0;
      end else begin
        res_d[i] = stg_q[NP-1].neg[i] ? -qv[i][15:0] : qv[i][15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NP-2:0], head_vld_i};
      out_vld_q <= vld_q[NP-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < NP; s++) begin
        stg_q[s] <= stg_d[s];
      end
      res_q  <= res_d;
      kind_q <= stg_q[NP-1].kind;
      zero_q <= (stg_q[NP-1].kind != stmg_pkg::KIND_FLIP) && stg_q[NP-1].zero;
    end
  end

  assign out_vld_o  = out_vld_q;
  assign out_res_o  = res_q;
  assign out_kind_o = kind_q;
  assign out_zero_o = zero_q;

endmodule

/* hw/rtl/spin_trial_move_generator_top.sv */
// Top level of the spin trial move generator with configuration registers.
// This block turns one old unit spin plus three Gaussian samples and one uniform sample into
// one trial spin per transaction, by flip, uniform or cone move as the move_mode register
// selects (combined mode draws the move from the uniform sample). It accepts one transaction
// per clock cycle while the queue is not full and delivers one result per cycle while the
// output side is ready; a result passes through the queue slot and the normalization pipeline
// (magnitude, leading-one search, block shift, squares, sum, three stages per Newton step for
// the reciprocal square root, the scaling multiply and the output register). A queue of
// QueueDepth entries separates the classifying front from the pipeline, so input is taken
// while a result waits at the output. Configuration writes must only be issued while the
// block is empty.
module spin_trial_move_generator_top #(
  parameter int unsigned RsqrtSteps = stmg_pkg::RsqrtStepsDflt,
  parameter int unsigned QueueDepth = stmg_pkg::QueueDepthDflt
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Fields from bit 0 up: old_x, old_y, old_z, gauss_x, gauss_y, gauss_z, pick_sample.
  input  logic [111:0] s_axis_tdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // Fields from bit 0 up: new_x, new_y, new_z.
  output logic [47:0]  m_axis_tdata_o,
  // Fields from bit 0 up: move_taken (2 bits), zero_length (1 bit).
  output logic [2:0]   m_axis_tuser_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_wdata_i
);

  // Configuration registers.
  logic [2:0]  move_mode_q;
  logic [15:0] cone_width_q;
  logic [15:0] adaptive_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_mode_q      <= stmg_pkg::MODE_ADAPT;
      cone_width_q     <= 16'd4096;
      adaptive_width_q <= 16'd4096;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        stmg_pkg::REG_MOVE_MODE:      move_mode_q      <= cfg_wdata_i[2:0];
        stmg_pkg::REG_CONE_WIDTH:     cone_width_q     <= cfg_wdata_i;
        stmg_pkg::REG_ADAPTIVE_WIDTH: adaptive_width_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [2:0][15:0]   old_f, gauss_f;
  stmg_pkg::q_entry_t entry, head;
  logic               q_full, q_empty, pop, push;

  assign old_f   = s_axis_tdata_i[47:0];
  assign gauss_f = s_axis_tdata_i[95:48];

  // The front classifies in the same cycle that the transaction is accepted.
  stmg_front u_front (
    .move_mode_i      (move_mode_q),
    .cone_width_i     (cone_width_q),
    .adaptive_width_i (adaptive_width_q),
    .old_i            (old_f),
    .gauss_i          (gauss_f),
    .pick_sample_i    (s_axis_tdata_i[111:96]),
    .entry_o          (entry)
  );

  assign s_axis_tready_o = !q_full;
  assign push            = s_axis_tvalid_i && !q_full;

  stmg_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (entry),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  logic [2:0][15:0] res;
  logic [1:0]       kind;
  logic             zero;

  stmg_back #(
    .RsqrtSteps (RsqrtSteps)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_vld_i (!q_empty),
    .head_i     (head),
    .pop_o      (pop),
    .out_vld_o  (m_axis_tvalid_o),
    .out_rdy_i  (m_axis_tready_i),
    .out_res_o  (res),
    .out_kind_o (kind),
    .out_zero_o (zero)
  );

  assign m_axis_tdata_o = res;
  assign m_axis_tuser_o = {zero, kind};

  // A flip move never normalizes, so it can never report a zero length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[1:0] == stmg_pkg::KIND_FLIP) |-> !m_axis_tuser_o[2])
    else $error("flip result flagged zero length");

  // A zero-length result carries an all-zero spin.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[2] |-> (m_axis_tdata_o == '0))
    else $error("zero-length result with nonzero spin");

  // Every delivered component lies within plus and minus one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ($signed(m_axis_tdata_o[15:0])  <= 16'sd16384) &&
      ($signed(m_axis_tdata_o[15:0])  >= -16'sd16384) &&
      ($signed(m_axis_tdata_o[31:16]) <= 16'sd16384) &&
      ($signed(m_axis_tdata_o[31:16]) >= -16'sd16384) &&
      ($signed(m_axis_tdata_o[47:32]) <= 16'sd16384) &&
      ($signed(m_axis_tdata_o[47:32]) >= -16'sd16384))
    else $error("trial spin component out of range");

endmodule
